[rtl/lmm_pkg.sv]
// ----------------------------------------------------------------------------
// lmm_pkg
// Shared types, widths and codes of the landmark map merge core.
// ----------------------------------------------------------------------------
package lmm_pkg;

  localparam int MAX_ENTRIES = 256;

  localparam int POS_W     = 24;
  localparam int WGT_W     = 24;
  localparam int SEEN_W    = 16;
  localparam int CLASS_W   = 2;
  localparam int CONF_W    = 17;
  localparam int REF_W     = 23;
  localparam int RAD_W     = 23;
  localparam int CAP_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_OUT_W = 8;

  // shared multiplier and divider sizes
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_NW = PROD_W;
  localparam int DIV_DW = 26;
  localparam int DIV_QW = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP      = 2'd2;

  localparam logic [REF_W-1:0] REF_DIST_RST = 23'd2560;
  localparam logic [RAD_W-1:0] RADIUS_RST   = 23'd384;
  localparam logic [CAP_W-1:0] CAP_RST      = 24'd655360;

  typedef enum logic [1:0] {
    STAT_ADDED   = 2'd0,
    STAT_MERGED  = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_CLEARED = 2'd3
  } status_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [POS_W-1:0]  det_x;
    logic signed [POS_W-1:0]  det_y;
    logic [CONF_W-1:0]        det_conf;
    logic [CLASS_W-1:0]       det_class;
    logic signed [POS_W-1:0]  car_x;
    logic signed [POS_W-1:0]  car_y;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [IDX_OUT_W-1:0]     entry_index;
    logic signed [POS_W-1:0]  entry_pos_x;
    logic signed [POS_W-1:0]  entry_pos_y;
    logic [WGT_W-1:0]         entry_weight;
    logic [SEEN_W-1:0]        sightings;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [WGT_W-1:0]   weight;
    logic [CLASS_W-1:0] cls;
    logic [SEEN_W-1:0]  seen;
  } entry_t;

  // magnitude of the difference of two signed positions
  function automatic logic [MUL_W-1:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[POS_W] ? MUL_W'(-d) : MUL_W'(d);
  endfunction

  // offset binary: signed position to unsigned by flipping the sign bit
  function automatic logic [POS_W-1:0] flip_sign(logic [POS_W-1:0] a);
    return {~a[POS_W-1], a[POS_W-2:0]};
  endfunction

endpackage

[rtl/lmm_if.sv]
// ----------------------------------------------------------------------------
// lmm_if
// Valid/ready channels for detection items and result items.
// ----------------------------------------------------------------------------
interface lmm_in_if;
  logic              valid;
  logic              ready;
  lmm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lmm_out_if;
  logic               valid;
  logic               ready;
  lmm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/landmark_map_merge_core.sv]
// ----------------------------------------------------------------------------
// landmark_map_merge_core
// Landmark table built from single detections: nearest-neighbor association
// within a radius and confidence-weighted position merge.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ch.ready is high only while the core is
// idle. For a detection the distance square root runs 25 iterations, the
// weight and, on a merge, each position are divided on the shared divider,
// and the table scan uses the single shared 25x25 multiplier for each stored
// entry. A finished result waits in the output register while the next item
// is accepted.
module landmark_map_merge_core #(
  parameter int MAX_ENTRIES = lmm_pkg::MAX_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lmm_in_if.sink                         in_ch,
  lmm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lmm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lmm_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = lmm_pkg::PROD_W;
  localparam int MW = lmm_pkg::MUL_W;
  localparam int XW = lmm_pkg::POS_W;

  localparam lmm_pkg::out_item_t RES_CLEARED = '{status: lmm_pkg::STAT_CLEARED, default: '0};
  localparam lmm_pkg::out_item_t RES_DROPPED = '{status: lmm_pkg::STAT_DROPPED, default: '0};

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_SQX   = 20'h00002,
    S_SQY   = 20'h00004,
    S_SQS   = 20'h00008,
    S_ROOT  = 20'h00010,
    S_WMUL  = 20'h00020,
    S_WGO   = 20'h00040,
    S_WWT   = 20'h00080,
    S_R2    = 20'h00100,
    S_SCAN0 = 20'h00200,
    S_MX    = 20'h00400,
    S_MY    = 20'h00800,
    S_CMP   = 20'h01000,
    S_DEC   = 20'h02000,
    S_MA    = 20'h04000,
    S_MB    = 20'h08000,
    S_MGO   = 20'h10000,
    S_MWT   = 20'h20000,
    S_MW    = 20'h40000,
    S_PUT   = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [lmm_pkg::REF_W-1:0] ref_r;
  logic [lmm_pkg::RAD_W-1:0] rad_r;
  logic [lmm_pkg::CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= lmm_pkg::REF_DIST_RST;
      rad_r <= lmm_pkg::RADIUS_RST;
      cap_r <= lmm_pkg::CAP_RST;
    end else if (cfg_we) begin
      if (cfg_idx == lmm_pkg::CFG_REF_DIST) ref_r <= cfg_data[lmm_pkg::REF_W-1:0];
      if (cfg_idx == lmm_pkg::CFG_RADIUS)   rad_r <= cfg_data[lmm_pkg::RAD_W-1:0];
      if (cfg_idx == lmm_pkg::CFG_CAP)      cap_r <= cfg_data[lmm_pkg::CAP_W-1:0];
    end
  end

  // working registers
  lmm_pkg::in_item_t          det_r;
  logic [MW-1:0]              abs_x_r, abs_y_r;
  logic [PW-1:0]              prod_r, acc_r;
  logic [PW-1:0]              sq_v_r, root_r, bit_r;
  logic [lmm_pkg::DIV_DW-1:0] den_r;
  logic [lmm_pkg::CONF_W-1:0] w_r;
  logic [PW-1:0]              best_r;
  logic                       found_r;
  logic [CW-1:0]              idx_r;
  logic [AW-1:0]              bi_r;
  logic [CW-1:0]              fill_r;
  logic                       axis_r;
  logic [XW-1:0]              newx_r, newy_r;
  lmm_pkg::out_item_t         res_r;
  lmm_pkg::out_item_t         out_data_r;
  logic                       out_valid_r;

  // table memory
  lmm_pkg::entry_t mem [MAX_ENTRIES];
  lmm_pkg::entry_t rd_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_wa, mem_ra;
  lmm_pkg::entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem[mem_ra];
  end

  // shared multiplier
  logic [MW-1:0] mul_a, mul_b;
  logic [XW-1:0] cur_pos, det_pos;

  assign cur_pos = axis_r ? rd_r.y : rd_r.x;
  assign det_pos = axis_r ? det_r.det_y : det_r.det_x;

  always_comb begin
    unique case (state_r)
      S_SQX:   begin mul_a = abs_x_r; mul_b = abs_x_r; end
      S_SQY:   begin mul_a = abs_y_r; mul_b = abs_y_r; end
      S_WMUL:  begin mul_a = MW'(det_r.det_conf); mul_b = MW'(ref_r); end
      S_R2:    begin mul_a = MW'(rad_r); mul_b = MW'(rad_r); end
      S_MX: begin
        mul_a = lmm_pkg::abs_diff(rd_r.x, det_r.det_x);
        mul_b = mul_a;
      end
      S_MY: begin
        mul_a = lmm_pkg::abs_diff(rd_r.y, det_r.det_y);
        mul_b = mul_a;
      end
      S_MA: begin
        mul_a = MW'(lmm_pkg::flip_sign(cur_pos));
        mul_b = MW'(rd_r.weight);
      end
      S_MB: begin
        mul_a = MW'(lmm_pkg::flip_sign(det_pos));
        mul_b = MW'(w_r);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // shared divider
  logic                       div_start;
  logic [PW-1:0]              div_num;
  logic [lmm_pkg::DIV_DW-1:0] div_den;
  logic                       div_done;
  logic [lmm_pkg::DIV_QW-1:0] div_quo;
  logic [lmm_pkg::WGT_W:0]    total;
  logic [PW-1:0]              avg_num;

  assign total   = {1'b0, rd_r.weight} + (lmm_pkg::WGT_W + 1)'(w_r);
  assign avg_num = acc_r + prod_r + PW'(total >> 1);

  always_comb begin
    div_start = 1'b0;
    div_num   = avg_num;
    div_den   = lmm_pkg::DIV_DW'(total);
    if (state_r == S_WGO) begin
      div_start = 1'b1;
      div_num   = prod_r;
      div_den   = den_r;
    end else if (state_r == S_MGO) begin
      div_start = 1'b1;
    end
  end

  lmm_div #(
    .NW (lmm_pkg::DIV_NW),
    .DW (lmm_pkg::DIV_DW),
    .QW (lmm_pkg::DIV_QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // square root step and scan compare
  logic [PW-1:0] root_try;
  logic [PW-1:0] scan_s;
  logic [AW-1:0] next_addr;
  logic          out_free;

  assign root_try  = root_r + bit_r;
  assign scan_s    = acc_r + prod_r;
  assign next_addr = AW'(idx_r + 1'b1);
  assign out_free  = !out_valid_r || out_ch.ready;

  // merged entry
  logic [XW-1:0]               mrg_x, mrg_y;
  logic [lmm_pkg::WGT_W-1:0]   mrg_w;
  logic [lmm_pkg::SEEN_W-1:0]  mrg_seen;

  // zero total weight keeps the stored position
  assign mrg_x    = (total == '0) ? rd_r.x : newx_r;
  assign mrg_y    = (total == '0) ? rd_r.y : newy_r;
  assign mrg_w    = (total < {1'b0, cap_r}) ? lmm_pkg::WGT_W'(total) : cap_r;
  assign mrg_seen = (rd_r.seen == '1) ? rd_r.seen : rd_r.seen + 1'b1;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_r[AW-1:0];
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = next_addr;
    unique case (state_r)
      S_SCAN0: begin
        mem_re = 1'b1;
        mem_ra = '0;
      end
      S_CMP: mem_re = 1'b1;
      S_DEC: begin
        if (found_r) begin
          mem_re = 1'b1;
          mem_ra = bi_r;
        end else if (fill_r != CW'(MAX_ENTRIES)) begin
          mem_we        = 1'b1;
          mem_wd.x      = det_r.det_x;
          mem_wd.y      = det_r.det_y;
          mem_wd.weight = lmm_pkg::WGT_W'(w_r);
          mem_wd.cls    = det_r.det_class;
          mem_wd.seen   = lmm_pkg::SEEN_W'(1);
        end
      end
      S_MW: begin
        mem_we        = 1'b1;
        mem_wa        = bi_r;
        mem_wd.x      = mrg_x;
        mem_wd.y      = mrg_y;
        mem_wd.weight = mrg_w;
        mem_wd.cls    = rd_r.cls;
        mem_wd.seen   = mrg_seen;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = in_ch.data.cmd ? S_PUT : S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_SQS;
      S_SQS:   state_nxt = S_ROOT;
      S_ROOT:  if (bit_r[0]) state_nxt = S_WMUL;
      S_WMUL:  state_nxt = S_WGO;
      S_WGO:   state_nxt = S_WWT;
      S_WWT:   if (div_done) state_nxt = S_R2;
      S_R2:    state_nxt = S_SCAN0;
      S_SCAN0: state_nxt = (fill_r == '0) ? S_DEC : S_MX;
      S_MX:    state_nxt = S_MY;
      S_MY:    state_nxt = S_CMP;
      S_CMP:   state_nxt = (idx_r + 1'b1 == fill_r) ? S_DEC : S_MX;
      S_DEC:   state_nxt = found_r ? S_MA : S_PUT;
      S_MA:    state_nxt = S_MB;
      S_MB:    state_nxt = S_MGO;
      S_MGO:   state_nxt = S_MWT;
      S_MWT:   if (div_done) state_nxt = axis_r ? S_MW : S_MA;
      S_MW:    state_nxt = S_PUT;
      S_PUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)            out_valid_r <= 1'b0;
      if (state_r == S_IDLE && in_ch.valid && in_ch.data.cmd) fill_r <= '0;
      if (state_r == S_DEC && !found_r && fill_r != CW'(MAX_ENTRIES)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        det_r   <= in_ch.data;
        abs_x_r <= lmm_pkg::abs_diff(in_ch.data.det_x, in_ch.data.car_x);
        abs_y_r <= lmm_pkg::abs_diff(in_ch.data.det_y, in_ch.data.car_y);
        res_r   <= RES_CLEARED;
      end
      S_SQY: acc_r <= prod_r;
      S_SQS: begin
        sq_v_r <= acc_r + prod_r;
        root_r <= '0;
        bit_r  <= PW'(1) << (PW - 2);
      end
      S_ROOT: begin
        if (sq_v_r >= root_try) begin
          sq_v_r <= sq_v_r - root_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_WMUL: den_r <= lmm_pkg::DIV_DW'(ref_r) + lmm_pkg::DIV_DW'(root_r);
      S_WWT: begin
        if (div_done) w_r <= (ref_r == '0) ? '0 : div_quo[lmm_pkg::CONF_W-1:0];
      end
      S_SCAN0: begin
        best_r  <= prod_r;
        found_r <= 1'b0;
        idx_r   <= '0;
        axis_r  <= 1'b0;
      end
      S_MY: acc_r <= prod_r;
      S_CMP: begin
        // strict compare keeps the lowest index on a tie
        if (scan_s < best_r) begin
          best_r  <= scan_s;
          bi_r    <= idx_r[AW-1:0];
          found_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      S_DEC: begin
        if (!found_r) begin
          if (fill_r == CW'(MAX_ENTRIES)) begin
            res_r <= RES_DROPPED;
          end else begin
            res_r.status       <= lmm_pkg::STAT_ADDED;
            res_r.entry_index  <= lmm_pkg::IDX_OUT_W'(fill_r);
            res_r.entry_pos_x  <= det_r.det_x;
            res_r.entry_pos_y  <= det_r.det_y;
            res_r.entry_weight <= lmm_pkg::WGT_W'(w_r);
            res_r.sightings    <= lmm_pkg::SEEN_W'(1);
          end
        end
      end
      S_MB: acc_r <= prod_r;
      S_MWT: begin
        if (div_done) begin
          if (axis_r) newy_r <= lmm_pkg::flip_sign(div_quo[XW-1:0]);
          else        newx_r <= lmm_pkg::flip_sign(div_quo[XW-1:0]);
          axis_r <= 1'b1;
        end
      end
      S_MW: begin
        res_r.status       <= lmm_pkg::STAT_MERGED;
        res_r.entry_index  <= lmm_pkg::IDX_OUT_W'(bi_r);
        res_r.entry_pos_x  <= mrg_x;
        res_r.entry_pos_y  <= mrg_y;
        res_r.entry_weight <= mrg_w;
        res_r.sightings    <= mrg_seen;
      end
      S_PUT: begin
        if (out_free) out_data_r <= res_r;
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

[rtl/lmm_div.sv]
// ----------------------------------------------------------------------------
// lmm_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module lmm_div #(
  parameter int NW = lmm_pkg::DIV_NW,
  parameter int DW = lmm_pkg::DIV_DW,
  parameter int QW = lmm_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [QW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DW:0]      trial;
  logic             ge;
  logic [DW:0]      diff;

  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(num >> QW);
      q_r   <= num[QW-1:0];
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
